[rtl/csmm_pkg.sv]
package csmm_pkg;

   localparam int PIXEL_W = 8;
   localparam int STEP_W  = $clog2(PIXEL_W);
   localparam logic [PIXEL_W-1:0] FULL_SCALE = 8'd255;
   localparam logic [PIXEL_W-1:0] LEVEL_MIN  = 8'd0;

   // how the back end turns a stretch pixel into a result
   typedef enum logic [1:0] {
      KIND_FLAT,
      KIND_ZERO,
      KIND_FULL,
      KIND_DIV
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [PIXEL_W-1:0]   delta;
      logic [PIXEL_W-1:0]   span;
   } entry_type;

endpackage

[rtl/csmm_front.sv]
module csmm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [csmm_pkg::PIXEL_W-1:0]  req_tdata,   // [7:0] pixel_in
   input  logic [1:0]                    req_tuser,   // [0] func, [1] frame_start
   input  logic                          q_full,
   output logic                          q_push,
   output csmm_pkg::entry_type           q_entry
);

   logic [csmm_pkg::PIXEL_W-1:0] min_ff, min_in;
   logic [csmm_pkg::PIXEL_W-1:0] max_ff, max_in;
   logic [csmm_pkg::PIXEL_W-1:0] base_min, base_max;
   logic                         accept;
   logic                         func;
   logic                         frame_start;
   logic [csmm_pkg::PIXEL_W-1:0] px;

   assign req_tready  = !q_full;
   assign accept      = req_tvalid && req_tready;
   assign func        = req_tuser[0];
   assign frame_start = req_tuser[1];
   assign px          = req_tdata;
   assign q_push      = accept && func;

   always_comb begin
      base_min = frame_start ? csmm_pkg::FULL_SCALE : min_ff;
      base_max = frame_start ? csmm_pkg::LEVEL_MIN : max_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      if (accept && !func) begin
         min_in = (px < base_min) ? px : base_min;
         max_in = (px > base_max) ? px : base_max;
      end
   end

   // stretch transfers are classified against the levels seen so far
   always_comb begin
      q_entry.delta = px - min_ff;
      q_entry.span  = max_ff - min_ff;
      if (max_ff <= min_ff) begin
         q_entry.kind = csmm_pkg::KIND_FLAT;
      end else if (px <= min_ff) begin
         q_entry.kind = csmm_pkg::KIND_ZERO;
      end else if (px >= max_ff) begin
         q_entry.kind = csmm_pkg::KIND_FULL;
      end else begin
         q_entry.kind = csmm_pkg::KIND_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= csmm_pkg::FULL_SCALE;
         max_ff <= csmm_pkg::LEVEL_MIN;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

endmodule

[rtl/csmm_queue.sv]
module csmm_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  csmm_pkg::entry_type  push_entry,
   input  logic                 pop,
   output csmm_pkg::entry_type  head_entry,
   output logic                 full,
   output logic                 empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   csmm_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full       = (count_ff == FULL_CNT);
   assign empty      = (count_ff == '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/csmm_back.sv]
module csmm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  csmm_pkg::entry_type           q_entry,
   output logic                          q_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [csmm_pkg::PIXEL_W-1:0]  rsp_tdata,   // [7:0] pixel_out
   output logic                          rsp_tuser    // [0] flat
);

   localparam int W = csmm_pkg::PIXEL_W;
   localparam logic [csmm_pkg::STEP_W-1:0] LAST_STEP = csmm_pkg::STEP_W'(W - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   state_type                   state_ff, state_in;
   logic [W-1:0]                rem_ff, rem_in;
   logic [W-1:0]                quo_ff, quo_in;
   logic [W-1:0]                span_ff, span_in;
   logic [csmm_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        flat_ff, flat_in;
   logic                        out_valid_ff, out_valid_in;
   logic [W-1:0]                out_pixel_ff, out_pixel_in;
   logic                        out_flat_ff, out_flat_in;

   logic [2*W-1:0] numer;
   logic [W:0]     trial;
   logic [W:0]     diff;
   logic           fits;
   logic           out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pixel_ff;
   assign rsp_tuser  = out_flat_ff;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign q_pop      = (state_ff == ST_IDLE) && !q_empty;

   // delta * 255 as (delta << 8) - delta
   assign numer = {q_entry.delta, W'(0)} - {W'(0), q_entry.delta};
   // one restoring step: remainder stays below span, so quotient fits 8 bits
   assign trial = {rem_ff, quo_ff[W-1]};
   assign diff  = trial - {1'b0, span_ff};
   assign fits  = (trial >= {1'b0, span_ff});

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      span_in      = span_ff;
      step_in      = step_ff;
      flat_in      = flat_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_pixel_in = out_pixel_ff;
      out_flat_in  = out_flat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               flat_in = 1'b0;
               span_in = q_entry.span;
               step_in = '0;
               case (q_entry.kind)
                  csmm_pkg::KIND_FLAT: begin
                     quo_in   = csmm_pkg::LEVEL_MIN;
                     flat_in  = 1'b1;
                     state_in = ST_HOLD;
                  end
                  csmm_pkg::KIND_ZERO: begin
                     quo_in   = csmm_pkg::LEVEL_MIN;
                     state_in = ST_HOLD;
                  end
                  csmm_pkg::KIND_FULL: begin
                     quo_in   = csmm_pkg::FULL_SCALE;
                     state_in = ST_HOLD;
                  end
                  csmm_pkg::KIND_DIV: begin
                     rem_in   = numer[2*W-1:W];
                     quo_in   = numer[W-1:0];
                     state_in = ST_RUN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RUN: begin
            rem_in  = fits ? diff[W-1:0] : trial[W-1:0];
            quo_in  = {quo_ff[W-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_pixel_in = quo_ff;
               out_flat_in  = flat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      span_ff      <= span_in;
      step_ff      <= step_in;
      flat_ff      <= flat_in;
      out_pixel_ff <= out_pixel_in;
      out_flat_ff  <= out_flat_in;
   end

endmodule

[rtl/contrast_stretch_min_max.sv]
// min/max linear contrast stretch for 8-bit grey pixels
// req channel: tdata = pixel_in, tuser = {frame_start, func}. each frame is sent
// twice: a scan pass (func 0) that tracks the min and max grey level, with
// frame_start on its first pixel, then a stretch pass (func 1).
// scan transfers give no result and are taken one per cycle while the queue
// has room. stretch transfers are classified against the current min/max and
// parked in a small queue (QUEUE_DEPTH entries), so later scan transfers do
// not disturb them.
// rsp channel: tdata = (pixel - min) * 255 / (max - min), tuser = flat (frame
// with no spread, pixel forced to 0). pixels outside [min, max] clip.
// the back end runs a restoring divider one quotient bit per cycle: a pixel
// strictly between min and max goes through pop, 8 divide steps and hand-off,
// a flat or clipped pixel through pop and hand-off. with the queue empty, the
// req transfer is registered in the queue, then passes these back end steps.
// a stalled rsp side holds the output register; the queue keeps taking
// transfers until it fills, then req_tready drops.
// reset: min = 255, max = 0, queue empty, no result pending.
module contrast_stretch_min_max #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_in
   input  logic [1:0]  req_tuser,   // [0] func, [1] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] pixel_out
   output logic        rsp_tuser    // [0] flat
);

   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_empty;
   csmm_pkg::entry_type push_entry;
   csmm_pkg::entry_type head_entry;

   csmm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   csmm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   csmm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_entry    (head_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_flat_is_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == csmm_pkg::LEVEL_MIN)
      else $error("flat result with nonzero pixel");

   a_queue_sane : assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue full and empty at once");

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("push into full queue");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam bit PASS_SCAN    = 1'b0;
   localparam bit PASS_STRETCH = 1'b1;
   localparam logic [7:0] FULL_LEVEL  = 8'd255;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         ITEM_COUNT  = 1650;
   localparam int         DRAIN_CYCLES = 40;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;    // [7:0] pixel_in
   logic [1:0] req_tuser = '0;    // [0] func, [1] frame_start
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // [7:0] pixel_out
   logic       rsp_tuser;         // [0] flat

   bit steady = 1'b0;    // no idling on either side while set
   int sent_items = 0;
   int cycles = 0;

   typedef struct {
      logic [7:0] level;
      bit         flat;
   } stretched_pixel_type;

   class stretch_scoreboard;
      logic [7:0]          lo_level;
      logic [7:0]          hi_level;
      stretched_pixel_type stretched_q[$];
      int                  mismatches;
      int                  scans;
      int                  stretches;
      int                  frames;
      int                  flats;
      int                  clips;

      function new();
         lo_level   = FULL_LEVEL;
         hi_level   = 8'd0;
         mismatches = 0;
         scans      = 0;
         stretches  = 0;
         frames     = 0;
         flats      = 0;
         clips      = 0;
      endfunction

      // track min/max on a scan transfer, predict the result of a stretch transfer
      function void note_pixel(bit fn, logic [7:0] px, bit fs);
         stretched_pixel_type res;
         int                  num;
         if (fn == PASS_SCAN) begin
            scans++;
            if (fs) begin
               lo_level = FULL_LEVEL;
               hi_level = 8'd0;
               frames++;
            end
            if (px < lo_level) lo_level = px;
            if (px > hi_level) hi_level = px;
         end else begin
            stretches++;
            res.flat = 1'b0;
            if (hi_level <= lo_level) begin
               res.flat  = 1'b1;
               res.level = 8'd0;
               flats++;
            end else if (px <= lo_level) begin
               res.level = 8'd0;
               if (px < lo_level) clips++;
            end else if (px >= hi_level) begin
               res.level = FULL_LEVEL;
               if (px > hi_level) clips++;
            end else begin
               num = (int'(px) - int'(lo_level)) * int'(FULL_LEVEL);
               res.level = 8'(num / (int'(hi_level) - int'(lo_level)));
            end
            stretched_q.push_back(res);
         end
      endfunction

      function void check_result(logic [7:0] level, logic flat);
         stretched_pixel_type exp_res;
         if (stretched_q.size() == 0) begin
            $error("result with nothing expected: pixel_out %0d, flat %0b", level, flat);
            mismatches++;
            return;
         end
         exp_res = stretched_q.pop_front();
         if (level !== exp_res.level) begin
            $error("pixel_out mismatch: expected %0d, actual %0d", exp_res.level, level);
            mismatches++;
         end
         if (flat !== exp_res.flat) begin
            $error("flat mismatch: expected %0b, actual %0b", exp_res.flat, flat);
            mismatches++;
         end
      endfunction
   endclass

   stretch_scoreboard board = new();

   contrast_stretch_min_max i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // result side: check each transfer, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(rsp_tdata, rsp_tuser);
      end
      rsp_tready <= steady || ($urandom_range(0, 99) >= 38);
   end

   // called just after a rising edge; returns just after the edge of the transfer
   task automatic send_pixel(input bit fn, input logic [7:0] px, input bit fs);
      while (!steady && $urandom_range(0, 99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= {fs, fn};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_pixel(fn, px, fs);
      sent_items++;
   endtask

   initial begin : stimulus
      logic [7:0] frame_px [12];
      int         len;
      int         lo_px;
      int         hi_px;
      int         pick;
      logic [7:0] px;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // nothing scanned since reset: flat, frame start on a stretch is ignored
      send_pixel(PASS_STRETCH, 8'd0, 1'b1);
      send_pixel(PASS_STRETCH, 8'd255, 1'b0);
      // single grey level frame
      send_pixel(PASS_SCAN, 8'd128, 1'b1);
      send_pixel(PASS_STRETCH, 8'd128, 1'b0);
      // continue the frame out to the full range
      send_pixel(PASS_SCAN, 8'd0, 1'b0);
      send_pixel(PASS_SCAN, 8'd255, 1'b0);
      send_pixel(PASS_STRETCH, 8'd0, 1'b0);
      send_pixel(PASS_STRETCH, 8'd255, 1'b0);
      send_pixel(PASS_STRETCH, 8'd1, 1'b0);
      send_pixel(PASS_STRETCH, 8'd254, 1'b0);
      send_pixel(PASS_STRETCH, 8'd127, 1'b0);
      send_pixel(PASS_STRETCH, 8'd128, 1'b0);
      // narrow frame with pixels clipping on both sides
      send_pixel(PASS_SCAN, 8'd100, 1'b1);
      send_pixel(PASS_SCAN, 8'd200, 1'b0);
      send_pixel(PASS_STRETCH, 8'd50, 1'b0);
      send_pixel(PASS_STRETCH, 8'd250, 1'b0);
      send_pixel(PASS_STRETCH, 8'd150, 1'b0);
      send_pixel(PASS_STRETCH, 8'd101, 1'b0);
      send_pixel(PASS_STRETCH, 8'd199, 1'b0);
      send_pixel(PASS_STRETCH, 8'd150, 1'b1);
      // flat white frame
      send_pixel(PASS_SCAN, 8'd255, 1'b1);
      send_pixel(PASS_STRETCH, 8'd255, 1'b0);

      while (sent_items < ITEM_COUNT) begin
         steady = (sent_items >= 700 && sent_items < 1000);
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            // scan pass then stretch pass of the same frame
            len   = $urandom_range(1, 12);
            lo_px = $urandom_range(0, 255);
            hi_px = (pick < 10) ? lo_px : $urandom_range(0, 255);
            for (int i = 0; i < len; i++) begin
               frame_px[i] = 8'($urandom_range(lo_px, hi_px));
               send_pixel(PASS_SCAN, frame_px[i], i == 0);
            end
            for (int i = 0; i < len; i++) begin
               px = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : frame_px[i];
               send_pixel(PASS_STRETCH, px, $urandom_range(0, 9) == 0);
            end
         end else if (pick < 90) begin
            // scan carries on without a frame start, then a short stretch
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) begin
               send_pixel(PASS_SCAN, 8'($urandom_range(0, 255)), 1'b0);
            end
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) begin
               send_pixel(PASS_STRETCH, 8'($urandom_range(0, 255)), 1'b0);
            end
         end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               send_pixel(bit'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          bit'($urandom_range(0, 1)));
            end
         end
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (board.stretched_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d scan and %0d stretch transfers in %0d cycles, %0d frames started",
               board.scans, board.stretches, cycles, board.frames);
      $display("%0d flat results, %0d clipped pixels", board.flats, board.clips);
      if (board.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[files.f]
rtl/csmm_pkg.sv
rtl/csmm_front.sv
rtl/csmm_queue.sv
rtl/csmm_back.sv
rtl/contrast_stretch_min_max.sv
bench/tb_top.sv
